/* design/kvpd_pkg.sv */
`default_nettype none
package kvpd_pkg;
   localparam int KEY_COUNT_DEF = 512;
   localparam int ADC_BITS_DEF = 12;
   localparam int KEY_W = 9;
   localparam int CODE_W = 12;
   localparam int TIME_W = 16;
   localparam int MS_W = 15;
   localparam int VEL_W = 7;
   localparam int QUO_W = 8;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_TRACK = 2'd1;
   localparam logic [1:0] PH_AFTER = 2'd2;

   localparam logic [1:0] EV_ON = 2'd0;
   localparam logic [1:0] EV_TOUCH = 2'd1;
   localparam logic [1:0] EV_OFF = 2'd2;

   localparam logic [2:0] REG_THR_LOW = 3'd0;
   localparam logic [2:0] REG_THR_HIGH = 3'd1;
   localparam logic [2:0] REG_SPLIT = 3'd2;
   localparam logic [2:0] REG_TRACK = 3'd3;
   localparam logic [2:0] REG_AFTER = 3'd4;

   typedef struct packed {
      logic start;
      logic [19:0] dividend;
      logic [12:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

/* design/kvpd_divider.sv */
`default_nettype none
module kvpd_divider
   import kvpd_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire div_req_type req,
   output div_rsp_type rsp
);
   logic [19:0] rem_ff, rem_in;
   logic [12:0] den_ff, den_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [3:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [20:0] trial;

   always_comb begin
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = 21'(den_ff) << cnt_ff;
      if (req.start) begin
         rem_in = req.dividend;
         den_in = req.divisor;
         quo_in = '0;
         cnt_in = 4'(QUO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (21'(rem_ff) >= trial) begin
            rem_in = rem_ff - trial[19:0];
            quo_in = quo_ff | (QUO_W'(1) << cnt_ff[2:0]);
         end
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = quo_ff;
endmodule
`default_nettype wire

/* design/key_velocity_peak_detector.sv */
`default_nettype none
// Each transfer is a sample, a millisecond tick or a full-scale write for one key. The per-key
// state lives in one synchronous memory of KEY_COUNT words, read, modified and written back
// while the block takes one item at a time. A tick or ignored item is done in the idle state, a
// sample or write passes the read and calculate states, and a sample that ends peak tracking
// with an in-range velocity also the divide and output states, waiting on the 8-step restoring
// divider. A sample or write waits in the calculate or output state while an earlier event is
// still held on the output. After reset the block clears the key memory, one key a cycle, before
// it accepts the first item; CSR writes are taken throughout.
module key_velocity_peak_detector
   import kvpd_pkg::*;
#(
   parameter int KEY_COUNT = KEY_COUNT_DEF,
   parameter int ADC_BITS = ADC_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [1:0] req_operation,
   input wire logic [KEY_W-1:0] req_key_index,
   input wire logic [CODE_W-1:0] req_sample_code,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [1:0] rsp_event_kind,
   output logic [KEY_W-1:0] rsp_event_key,
   output logic [VEL_W-1:0] rsp_velocity,
   output logic rsp_velocity_clamped,
   input wire logic psel,
   input wire logic penable,
   input wire logic pwrite,
   input wire logic [4:0] paddr,
   input wire logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int CW = $clog2(KEY_COUNT + 1);
   localparam logic [CODE_W-1:0] ADC_MASK = CODE_W'((1 << ADC_BITS) - 1);
   // word: phase 2, peak 12, start 16, playing 1, rest 12, valid 1, full 12
   localparam int WW = 56;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_CALC = 3'd3;
   localparam logic [2:0] ST_DIV = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;

   logic [WW-1:0] mem [KEY_COUNT];
   logic [WW-1:0] rd_ff;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [WW-1:0] wr_data;

   logic [2:0] st_ff, st_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [TIME_W-1:0] ms_ff, ms_in;
   logic [1:0] op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [CODE_W-1:0] code_ff;
   logic [WW-1:0] upd_ff, upd_in;
   logic [CODE_W-1:0] thr_ff, thr_in;
   logic [CODE_W-1:0] thr_low_ff, thr_high_ff;
   logic [9:0] split_ff;
   logic [MS_W-1:0] track_ff, after_ff;
   logic [1:0] ev_kind_ff, ev_kind_in;
   logic [VEL_W-1:0] ev_vel_ff, ev_vel_in;
   logic ev_clamp_ff, ev_clamp_in;
   logic emit_in;
   logic out_busy;
   div_req_type dreq;
   div_rsp_type drsp;

   logic [1:0] r_phase;
   logic [CODE_W-1:0] r_peak, r_rest, r_full, rest, swing, peak;
   logic [TIME_W-1:0] r_start, elapsed;
   logic r_play, r_valid;
   logic [12:0] num, den;
   logic [19:0] num126;
   logic [20:0] den127;

   kvpd_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign pready = 1'b1;
   assign req_ready = (st_ff == ST_IDLE);
   assign out_busy = rsp_valid && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_low_ff <= 12'd372;
         thr_high_ff <= 12'd496;
         split_ff <= 10'd267;
         track_ff <= 15'd10;
         after_ff <= 15'd50;
      end else if (psel && penable && pwrite) begin
         case (paddr[4:2])
            REG_THR_LOW: thr_low_ff <= pwdata[11:0];
            REG_THR_HIGH: thr_high_ff <= pwdata[11:0];
            REG_SPLIT: split_ff <= pwdata[9:0];
            REG_TRACK: track_ff <= pwdata[14:0];
            REG_AFTER: after_ff <= pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_THR_LOW: prdata = 32'(thr_low_ff);
         REG_THR_HIGH: prdata = 32'(thr_high_ff);
         REG_SPLIT: prdata = 32'(split_ff);
         REG_TRACK: prdata = 32'(track_ff);
         REG_AFTER: prdata = 32'(after_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[(st_ff == ST_IDLE) ? AW'(req_key_index) : AW'(key_ff)];
   end

   always_comb begin
      {r_phase, r_peak, r_start, r_play, r_rest, r_valid, r_full} = rd_ff;
      rest = r_valid ? r_rest : code_ff;
      swing = (code_ff >= rest) ? code_ff - rest : rest - code_ff;
      peak = (swing > r_peak) ? swing : r_peak;
      elapsed = ms_ff - r_start;
      num = {1'b0, peak} - {1'b0, thr_ff};
      den = {1'b0, r_full} - {1'b0, thr_ff};
      num126 = 20'(num[11:0]) * 20'd126;
      den127 = 21'(den[11:0]) * 21'd127;
   end

   always_comb begin
      st_in = st_ff;
      clr_in = clr_ff;
      ms_in = ms_ff;
      upd_in = upd_ff;
      thr_in = thr_ff;
      ev_kind_in = ev_kind_ff;
      ev_vel_in = ev_vel_ff;
      ev_clamp_in = ev_clamp_ff;
      emit_in = 1'b0;
      wr_en = 1'b0;
      wr_addr = AW'(key_ff);
      wr_data = upd_ff;
      dreq.start = 1'b0;
      dreq.dividend = num126;
      dreq.divisor = den;
      case (st_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff[AW-1:0];
            wr_data = {PH_IDLE, 12'd0, 16'd0, 1'b0, 12'd0, 1'b0, ADC_MASK};
            clr_in = clr_ff + CW'(1);
            if (clr_ff == CW'(KEY_COUNT - 1)) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               thr_in = (10'(req_key_index) <= split_ff) ? thr_low_ff : thr_high_ff;
               if (req_operation == OP_TICK) ms_in = ms_ff + 16'd1;
               else if ((req_operation == OP_SAMPLE || req_operation == OP_WRITE)
                        && 32'(req_key_index) < KEY_COUNT)
                  st_in = ST_READ;
            end
         end
         ST_READ: st_in = ST_CALC;
         ST_CALC: begin
            if (!out_busy) begin
               st_in = ST_IDLE;
               wr_en = 1'b1;
               if (op_ff == OP_WRITE) begin
                  wr_data = {r_phase, r_peak, r_start, r_play, r_rest, r_valid,
                             code_ff & ADC_MASK};
               end else if (r_phase == PH_IDLE) begin
                  if (swing > thr_ff)
                     wr_data = {PH_TRACK, swing, ms_ff, 1'b0, rest, 1'b1, r_full};
                  else
                     wr_data = {r_phase, r_peak, r_start, r_play, rest, 1'b1, r_full};
               end else if (r_phase == PH_TRACK) begin
                  if (elapsed < 16'(track_ff)) begin
                     wr_data = {r_phase, peak, r_start, r_play, rest, 1'b1, r_full};
                  end else begin
                     ev_kind_in = r_play ? EV_TOUCH : EV_ON;
                     ev_clamp_in = 1'b0;
                     ev_vel_in = 7'd1;
                     upd_in = {PH_AFTER, peak, ms_ff, 1'b1, rest, 1'b1, r_full};
                     if (num[12] || num == 13'd0) begin
                        wr_data = upd_in;
                        emit_in = 1'b1;
                     end else if (den[12] || den == 13'd0 || 21'(num126) >= den127) begin
                        ev_vel_in = 7'd127;
                        ev_clamp_in = 1'b1;
                        wr_data = {PH_AFTER, peak, ms_ff, 1'b1, rest, 1'b1, peak};
                        emit_in = 1'b1;
                     end else begin
                        wr_en = 1'b0;
                        dreq.start = 1'b1;
                        st_in = ST_DIV;
                     end
                  end
               end else begin
                  if (swing > thr_ff) begin
                     wr_data = {PH_TRACK, r_peak, ms_ff, r_play, rest, 1'b1, r_full};
                  end else if (elapsed > 16'(after_ff)) begin
                     wr_data = {PH_IDLE, r_peak, r_start, 1'b0, rest, 1'b1, r_full};
                     ev_kind_in = EV_OFF;
                     ev_vel_in = 7'd0;
                     ev_clamp_in = 1'b0;
                     emit_in = 1'b1;
                  end else begin
                     wr_data = {r_phase, r_peak, r_start, r_play, rest, 1'b1, r_full};
                  end
               end
            end
         end
         ST_DIV: begin
            if (drsp.done) begin
               ev_vel_in = 7'(drsp.quotient) + 7'd1;
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_busy) begin
               wr_en = 1'b1;
               emit_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_IDLE && req_valid && req_ready) begin
         op_ff <= req_operation;
         key_ff <= req_key_index;
         code_ff <= req_sample_code;
      end
      upd_ff <= upd_in;
      thr_ff <= thr_in;
      ev_kind_ff <= ev_kind_in;
      ev_vel_ff <= ev_vel_in;
      ev_clamp_ff <= ev_clamp_in;
      if (reset) begin
         st_ff <= ST_CLEAR;
         clr_ff <= '0;
         ms_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         st_ff <= st_in;
         clr_ff <= clr_in;
         ms_ff <= ms_in;
         if (emit_in) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
      if (emit_in) begin
         rsp_event_kind <= ev_kind_in;
         rsp_event_key <= key_ff;
         rsp_velocity <= ev_vel_in;
         rsp_velocity_clamped <= ev_clamp_in;
      end
   end
endmodule
`default_nettype wire
